// ===== design/shipdb_pkg.sv =====
// shared constants, types and helpers of the signature-based replacement policy
`timescale 1ns / 1ps
`default_nettype none

package shipdb_pkg;

   // port field widths
   localparam int SET_IN_BITS = 11;
   localparam int WAY_IN_BITS = 4;
   localparam int SIG_IN_BITS = 6;

   // default geometry
   localparam int NUM_SETS_DEF = 2048;
   localparam int NUM_WAYS_DEF = 16;
   localparam int SIG_BITS_DEF = 6;

   // per-block and per-signature counter codes
   localparam logic [1:0] RR_MAX         = 2'd3;
   localparam logic [1:0] RR_NEAR        = 2'd0;
   localparam logic [1:0] DEAD_MAX       = 2'd3;
   localparam logic [1:0] DEAD_FILL      = 2'd1;
   localparam logic [1:0] DEAD_NONE      = 2'd0;
   localparam logic [1:0] OUTCOME_REUSED = 2'd2;
   localparam logic [1:0] OUTCOME_INIT   = 2'd1;
   localparam logic [1:0] OUTCOME_TOP    = 2'd3;
   localparam logic [1:0] OUTCOME_BOTTOM = 2'd0;

   // fill tally, decay fires when it wraps
   localparam int              TALLY_BITS = 12;
   localparam logic [TALLY_BITS-1:0] TALLY_LAST = 12'hFFF;

   // transaction function codes
   localparam logic FUNC_QUERY  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_ROW,
      S_FILL,
      S_DECAY
   } state_type;

   // largest shift k with n << k still below 2^SET_IN_BITS
   function automatic int mod_top(input int n);
      int k;
      k = 0;
      for (int i = 1; i < SET_IN_BITS; i++) begin
         if ((n << i) < (1 << SET_IN_BITS)) begin
            k = i;
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== design/ship_deadblock_cache_replacement.sv =====
// top level of the signature-based re-reference replacement policy with dead counters
`timescale 1ns / 1ps
`default_nettype none

// Replacement policy for a last-level cache. A transaction is taken when start is high
// and busy is low; busy stays high while it is worked on. All per-block state of a set
// lives in one row of a set memory (one read port, one write port, registered read),
// and the per-signature outcome counters in a second small memory. A query, and an
// update with a valid way, read the set row; a hit, a fill and a query that finds no
// dead block write it back. A query or a hit passes through S_ROW, a fill through S_ROW
// and S_FILL; an update with an invalid way is dropped. A victim query answers with
// rsp_valid high for exactly one cycle, registered from S_ROW; the receiver cannot
// hold it off. When NUM_SETS is not a power of two and below 2048, the set number is
// first reduced by a shift-and-subtract unit in S_MOD. Every 4096th fill starts a decay
// sweep over the set memory that keeps busy high. After reset a clearing pass
// initializes both memories with busy high.
module ship_deadblock_cache_replacement #(
   parameter int NUM_SETS = shipdb_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = shipdb_pkg::NUM_WAYS_DEF,
   parameter int SIG_BITS = shipdb_pkg::SIG_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire logic                                 req_func,
   input  wire logic [shipdb_pkg::SET_IN_BITS-1:0]   req_set_index,
   input  wire logic [shipdb_pkg::WAY_IN_BITS-1:0]   req_way,
   input  wire logic                                 req_hit,
   input  wire logic [shipdb_pkg::SIG_IN_BITS-1:0]   req_pc_signature,
   output      logic                                 rsp_valid,
   output      logic [shipdb_pkg::WAY_IN_BITS-1:0]   rsp_evict_way
);

   localparam int SB          = shipdb_pkg::SET_IN_BITS;
   localparam int SET_BITS    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_BITS    = $clog2(NUM_WAYS);
   localparam int ENT_W       = SIG_BITS + 4;
   localparam int ROW_W       = NUM_WAYS * ENT_W;
   localparam int SIG_ENTRIES = 1 << SIG_BITS;
   localparam int MAXD        = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int SWP_BITS    = $clog2(MAXD + 1);
   localparam bit NEED_MOD    = (NUM_SETS < (1 << SB)) &&
                                ((NUM_SETS & (NUM_SETS - 1)) != 0);
   localparam int MOD_TOP     = shipdb_pkg::mod_top(NUM_SETS);
   localparam logic [SB-1:0] SET_MASK =
      (NUM_SETS < (1 << SB)) ? SB'(NUM_SETS - 1) : {SB{1'b1}};
   localparam logic [ENT_W-1:0] ENT_RESET = ENT_W'(shipdb_pkg::RR_MAX);
   localparam logic [ROW_W-1:0] RESET_ROW = {NUM_WAYS{ENT_RESET}};

   // control and payload registers
   shipdb_pkg::state_type state_ff, state_in;
   logic [SWP_BITS-1:0]   sweep_ff, sweep_in;
   logic [SB-1:0]         set_ff, set_in;
   logic [SB-1:0]         div_ff, div_in;
   logic [3:0]            mstep_ff, mstep_in;
   logic                  func_ff, func_in;
   logic                  hit_ff, hit_in;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic [SIG_BITS-1:0]   sig_ff, sig_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [1:0]            outc_sig_ff, outc_sig_in;
   logic [SIG_BITS-1:0]   old_sig_ff, old_sig_in;
   logic [shipdb_pkg::TALLY_BITS-1:0] tally_ff, tally_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [shipdb_pkg::WAY_IN_BITS-1:0] rsp_way_ff, rsp_way_in;

   // memory ports
   logic                  row_wr_en, row_rd_en;
   logic [SET_BITS-1:0]   row_wr_addr, row_rd_addr;
   logic [ROW_W-1:0]      row_wr_data, row_rd_data;
   logic                  outc_wr_en, outc_rd_en;
   logic [SIG_BITS-1:0]   outc_wr_addr, outc_rd_addr;
   logic [1:0]            outc_wr_data, outc_rd_data;

   // victim search and row rewrites
   logic                  any_dead;
   logic [WAY_BITS-1:0]   dead_way;
   logic [WAY_BITS-1:0]   top_way;
   logic [1:0]            top_rr;
   logic                  any_rr3, any_rr2, any_rr1;
   logic [1:0]            lift;
   logic [ROW_W-1:0]      aged_row;
   logic [ROW_W-1:0]      decay_row;
   logic                  accept;
   logic                  way_ok;
   logic [SB-1:0]         rem_next;
   logic [1:0]            outc_dec;
   logic [1:0]            outc_new_sig;

   shipdb_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   shipdb_ram #(
      .WIDTH (2),
      .DEPTH (SIG_ENTRIES)
   ) u_outcome_ram (
      .clock   (clock),
      .wr_en   (outc_wr_en),
      .wr_addr (outc_wr_addr),
      .wr_data (outc_wr_data),
      .rd_en   (outc_rd_en),
      .rd_addr (outc_rd_addr),
      .rd_data (outc_rd_data)
   );

   assign accept = start && (state_ff == shipdb_pkg::S_IDLE);
   assign way_ok = 32'(req_way) < 32'(NUM_WAYS);

   // victim search over the row just read
   always_comb begin
      any_rr3  = 1'b0;
      any_rr2  = 1'b0;
      any_rr1  = 1'b0;
      any_dead = 1'b0;
      dead_way = '0;
      top_way  = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         any_rr3 = any_rr3 || (row_rd_data[w*ENT_W +: 2] == 2'd3);
         any_rr2 = any_rr2 || (row_rd_data[w*ENT_W +: 2] == 2'd2);
         any_rr1 = any_rr1 || (row_rd_data[w*ENT_W +: 2] == 2'd1);
      end
      if (any_rr3) begin
         top_rr = 2'd3;
      end else if (any_rr2) begin
         top_rr = 2'd2;
      end else if (any_rr1) begin
         top_rr = 2'd1;
      end else begin
         top_rr = 2'd0;
      end
      lift = shipdb_pkg::RR_MAX - top_rr;
      // lowest way wins, so scan downward
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row_rd_data[w*ENT_W + 2 +: 2] == shipdb_pkg::DEAD_MAX) begin
            any_dead = 1'b1;
            dead_way = WAY_BITS'(w);
         end
         if (row_rd_data[w*ENT_W +: 2] == top_rr) begin
            top_way = WAY_BITS'(w);
         end
      end
      // age every way by the same lift, decay every dead counter
      aged_row  = row_rd_data;
      decay_row = row_rd_data;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row[w*ENT_W +: 2] = row_rd_data[w*ENT_W +: 2] + lift;
         if (row_rd_data[w*ENT_W + 2 +: 2] != shipdb_pkg::DEAD_NONE) begin
            decay_row[w*ENT_W + 2 +: 2] = row_rd_data[w*ENT_W + 2 +: 2] - 2'd1;
         end
      end
   end

   // shift-and-subtract step of the set reduction
   assign rem_next = (set_ff >= div_ff) ? (set_ff - div_ff) : set_ff;

   // outcome counter arithmetic of a fill
   assign outc_dec     = (outc_rd_data == shipdb_pkg::OUTCOME_BOTTOM) ?
                         shipdb_pkg::OUTCOME_BOTTOM : (outc_rd_data - 2'd1);
   assign outc_new_sig = (old_sig_ff == sig_ff) ? outc_dec : outc_sig_ff;

   // next state, memory control and result
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      set_in       = set_ff;
      div_in       = div_ff;
      mstep_in     = mstep_ff;
      func_in      = func_ff;
      hit_in       = hit_ff;
      way_in       = way_ff;
      sig_in       = sig_ff;
      row_in       = row_ff;
      outc_sig_in  = outc_sig_ff;
      old_sig_in   = old_sig_ff;
      tally_in     = tally_ff;
      rsp_valid_in = 1'b0;
      rsp_way_in   = rsp_way_ff;
      row_wr_en    = 1'b0;
      row_wr_addr  = SET_BITS'(set_ff);
      row_wr_data  = row_rd_data;
      row_rd_en    = 1'b0;
      row_rd_addr  = SET_BITS'(set_ff);
      outc_wr_en   = 1'b0;
      outc_wr_addr = sig_ff;
      outc_wr_data = outc_rd_data;
      outc_rd_en   = 1'b0;
      outc_rd_addr = sig_ff;

      unique case (state_ff)
         // initialize both memories after reset
         shipdb_pkg::S_CLEAR: begin
            if (sweep_ff < SWP_BITS'(NUM_SETS)) begin
               row_wr_en   = 1'b1;
               row_wr_addr = sweep_ff[SET_BITS-1:0];
               row_wr_data = RESET_ROW;
            end
            if (sweep_ff < SWP_BITS'(SIG_ENTRIES)) begin
               outc_wr_en   = 1'b1;
               outc_wr_addr = sweep_ff[SIG_BITS-1:0];
               outc_wr_data = shipdb_pkg::OUTCOME_INIT;
            end
            if (sweep_ff == SWP_BITS'(MAXD - 1)) begin
               state_in = shipdb_pkg::S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         // take a transaction
         shipdb_pkg::S_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               hit_in   = req_hit;
               way_in   = WAY_BITS'(req_way);
               sig_in   = SIG_BITS'(req_pc_signature);
               div_in   = SB'(NUM_SETS << MOD_TOP);
               mstep_in = 4'(MOD_TOP);
               if (NEED_MOD) begin
                  set_in = req_set_index;
               end else begin
                  set_in = req_set_index & SET_MASK;
               end
               if ((req_func == shipdb_pkg::FUNC_UPDATE) && !way_ok) begin
                  state_in = shipdb_pkg::S_IDLE;
               end else if (NEED_MOD) begin
                  state_in = shipdb_pkg::S_MOD;
               end else begin
                  row_rd_en    = 1'b1;
                  row_rd_addr  = SET_BITS'(req_set_index & SET_MASK);
                  outc_rd_en   = 1'b1;
                  outc_rd_addr = SIG_BITS'(req_pc_signature);
                  state_in     = shipdb_pkg::S_ROW;
               end
            end
         end

         // reduce the set number, one subtract a cycle
         shipdb_pkg::S_MOD: begin
            set_in = rem_next;
            div_in = div_ff >> 1;
            if (mstep_ff == 4'd0) begin
               row_rd_en    = 1'b1;
               row_rd_addr  = SET_BITS'(rem_next);
               outc_rd_en   = 1'b1;
               outc_rd_addr = sig_ff;
               state_in     = shipdb_pkg::S_ROW;
            end else begin
               mstep_in = mstep_ff - 4'd1;
            end
         end

         // set row and outcome counter of the signature are valid
         shipdb_pkg::S_ROW: begin
            if (func_ff == shipdb_pkg::FUNC_QUERY) begin
               rsp_valid_in = 1'b1;
               if (any_dead) begin
                  rsp_way_in = shipdb_pkg::WAY_IN_BITS'(dead_way);
               end else begin
                  rsp_way_in  = shipdb_pkg::WAY_IN_BITS'(top_way);
                  row_wr_en   = 1'b1;
                  row_wr_data = aged_row;
               end
               state_in = shipdb_pkg::S_IDLE;
            end else if (hit_ff) begin
               row_wr_en   = 1'b1;
               row_wr_data = row_rd_data;
               row_wr_data[32'(way_ff)*ENT_W +: ENT_W] =
                  {sig_ff, shipdb_pkg::DEAD_NONE, shipdb_pkg::RR_NEAR};
               row_wr_data[32'(way_ff)*ENT_W + 4 +: SIG_BITS] =
                  row_rd_data[32'(way_ff)*ENT_W + 4 +: SIG_BITS];
               outc_wr_en   = 1'b1;
               outc_wr_data = (outc_rd_data == shipdb_pkg::OUTCOME_TOP) ?
                              shipdb_pkg::OUTCOME_TOP : (outc_rd_data + 2'd1);
               state_in     = shipdb_pkg::S_IDLE;
            end else begin
               // fill: fetch the counter of the evicted block's signature
               row_in       = row_rd_data;
               outc_sig_in  = outc_rd_data;
               old_sig_in   = row_rd_data[32'(way_ff)*ENT_W + 4 +: SIG_BITS];
               outc_rd_en   = 1'b1;
               outc_rd_addr = row_rd_data[32'(way_ff)*ENT_W + 4 +: SIG_BITS];
               state_in     = shipdb_pkg::S_FILL;
            end
         end

         // fill: punish old signature, store new block
         shipdb_pkg::S_FILL: begin
            outc_wr_en   = 1'b1;
            outc_wr_addr = old_sig_ff;
            outc_wr_data = outc_dec;
            row_wr_en    = 1'b1;
            row_wr_data  = row_ff;
            row_wr_data[32'(way_ff)*ENT_W +: ENT_W] =
               {sig_ff, shipdb_pkg::DEAD_FILL,
                (outc_new_sig >= shipdb_pkg::OUTCOME_REUSED) ?
                   shipdb_pkg::RR_NEAR : shipdb_pkg::RR_MAX};
            tally_in = tally_ff + 1'b1;
            if (tally_ff == shipdb_pkg::TALLY_LAST) begin
               sweep_in = '0;
               state_in = shipdb_pkg::S_DECAY;
            end else begin
               state_in = shipdb_pkg::S_IDLE;
            end
         end

         // decay sweep: read row n while writing back row n-1
         shipdb_pkg::S_DECAY: begin
            if (sweep_ff < SWP_BITS'(NUM_SETS)) begin
               row_rd_en   = 1'b1;
               row_rd_addr = sweep_ff[SET_BITS-1:0];
            end
            if (sweep_ff != '0) begin
               row_wr_en   = 1'b1;
               row_wr_addr = SET_BITS'(sweep_ff - 1'b1);
               row_wr_data = decay_row;
            end
            if (sweep_ff == SWP_BITS'(NUM_SETS)) begin
               state_in = shipdb_pkg::S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         default: begin
            state_in = shipdb_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shipdb_pkg::S_CLEAR;
         sweep_ff     <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      div_ff      <= div_in;
      mstep_ff    <= mstep_in;
      func_ff     <= func_in;
      hit_ff      <= hit_in;
      way_ff      <= way_in;
      sig_ff      <= sig_in;
      row_ff      <= row_in;
      outc_sig_ff <= outc_sig_in;
      old_sig_ff  <= old_sig_in;
      rsp_way_ff  <= rsp_way_in;
   end

   assign busy          = (state_ff != shipdb_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_evict_way = rsp_way_ff;

endmodule

`default_nettype wire

// ===== design/shipdb_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
`timescale 1ns / 1ps
`default_nettype none

module shipdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [ADDR_BITS-1:0]           wr_addr,
   input  wire logic [WIDTH-1:0]               wr_data,
   input  wire logic                           rd_en,
   input  wire logic [ADDR_BITS-1:0]           rd_addr,
   output      logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== bench/ship_deadblock_checker.sv =====
// checker for the replacement policy: predicts victim answers and compares them
`timescale 1ns / 1ps

module ship_deadblock_checker #(
   parameter int NUM_SETS = shipdb_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = shipdb_pkg::NUM_WAYS_DEF,
   parameter int SIG_BITS = shipdb_pkg::SIG_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 req_func,
   input  logic [shipdb_pkg::SET_IN_BITS-1:0]   req_set_index,
   input  logic [shipdb_pkg::WAY_IN_BITS-1:0]   req_way,
   input  logic                                 req_hit,
   input  logic [shipdb_pkg::SIG_IN_BITS-1:0]   req_pc_signature,
   input  logic                                 rsp_valid,
   input  logic [shipdb_pkg::WAY_IN_BITS-1:0]   rsp_evict_way,
   output int                                   fail_count,
   output int                                   pending
);

   import shipdb_pkg::*;

   localparam int SIG_COUNT = 1 << SIG_BITS;

   // shadow copy of the per-block and per-signature state
   logic [1:0]            reref_tab   [NUM_SETS][NUM_WAYS];
   logic [SIG_BITS-1:0]   blk_sig_tab [NUM_SETS][NUM_WAYS];
   logic [1:0]            dead_tab    [NUM_SETS][NUM_WAYS];
   logic [1:0]            outcome_tab [SIG_COUNT];
   logic [TALLY_BITS-1:0] fill_tally;

   // victim answers still owed by the block, oldest first
   logic [WAY_IN_BITS-1:0] victim_q [$];
   logic [WAY_IN_BITS-1:0] owed_way;
   int                     fails;

   assign fail_count = fails;

   // victim choice: a dead block first, else the first distant block after aging
   function automatic logic [WAY_IN_BITS-1:0] choose_victim(input int s);
      logic [1:0] top;
      logic [1:0] lift;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (dead_tab[s][w] == DEAD_MAX) begin
            return WAY_IN_BITS'(w);
         end
      end
      top = RR_NEAR;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (reref_tab[s][w] > top) begin
            top = reref_tab[s][w];
         end
      end
      lift = RR_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         reref_tab[s][w] = reref_tab[s][w] + lift;
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (reref_tab[s][w] == RR_MAX) begin
            return WAY_IN_BITS'(w);
         end
      end
      return '0;
   endfunction

   // hit or fill of one block, with the decay sweep on tally wrap
   task automatic apply_access(input int s, input int w, input logic is_hit,
                               input logic [SIG_BITS-1:0] sig);
      logic [SIG_BITS-1:0] old_sig;
      if (is_hit) begin
         reref_tab[s][w] = RR_NEAR;
         if (outcome_tab[sig] != OUTCOME_TOP) begin
            outcome_tab[sig] = outcome_tab[sig] + 2'd1;
         end
         dead_tab[s][w] = DEAD_NONE;
      end else begin
         old_sig = blk_sig_tab[s][w];
         if (outcome_tab[old_sig] != OUTCOME_BOTTOM) begin
            outcome_tab[old_sig] = outcome_tab[old_sig] - 2'd1;
         end
         blk_sig_tab[s][w] = sig;
         reref_tab[s][w] = (outcome_tab[sig] >= OUTCOME_REUSED) ? RR_NEAR : RR_MAX;
         dead_tab[s][w] = DEAD_FILL;
         if (fill_tally == TALLY_LAST) begin
            fill_tally = '0;
            for (int i = 0; i < NUM_SETS; i++) begin
               for (int j = 0; j < NUM_WAYS; j++) begin
                  if (dead_tab[i][j] != DEAD_NONE) begin
                     dead_tab[i][j] = dead_tab[i][j] - 2'd1;
                  end
               end
            end
         end else begin
            fill_tally = fill_tally + 1'b1;
         end
      end
   endtask

   // results are matched before a new transaction is taken in the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SETS; i++) begin
            for (int j = 0; j < NUM_WAYS; j++) begin
               reref_tab[i][j]   = RR_MAX;
               blk_sig_tab[i][j] = '0;
               dead_tab[i][j]    = DEAD_NONE;
            end
         end
         for (int k = 0; k < SIG_COUNT; k++) begin
            outcome_tab[k] = OUTCOME_INIT;
         end
         fill_tally = '0;
         victim_q.delete();
         fails = 0;
      end else begin
         // compare the answer with the oldest open query
         if (rsp_valid) begin
            if (victim_q.size() == 0) begin
               $error("evict_way: result %0d arrived with no query outstanding",
                      rsp_evict_way);
               fails = fails + 1;
            end else begin
               owed_way = victim_q.pop_front();
               if (rsp_evict_way !== owed_way) begin
                  $error("evict_way mismatch: expected %0d, actual %0d",
                         owed_way, rsp_evict_way);
                  fails = fails + 1;
               end
            end
         end
         // predict each accepted transaction in order
         if (start && !busy) begin
            if (req_func == FUNC_QUERY) begin
               victim_q.push_back(choose_victim(int'(req_set_index) % NUM_SETS));
            end else if (int'(req_way) < NUM_WAYS) begin
               apply_access(int'(req_set_index) % NUM_SETS, int'(req_way), req_hit,
                            SIG_BITS'(req_pc_signature));
            end
         end
      end
      pending = victim_q.size();
   end

endmodule

// ===== bench/ship_deadblock_cache_replacement_tb.sv =====
// top of the replacement policy testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module ship_deadblock_cache_replacement_tb;

   import shipdb_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int HOT_SETS    = 6;
   localparam int SIG_POOL    = 8;
   localparam int RAND_OPS    = 980;
   localparam int SET_TOP     = (1 << SET_IN_BITS) - 1;
   localparam int WAY_TOP     = (1 << WAY_IN_BITS) - 1;
   localparam int SIG_TOP     = (1 << SIG_IN_BITS) - 1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_func = FUNC_QUERY;
   logic [SET_IN_BITS-1:0] req_set_index = '0;
   logic [WAY_IN_BITS-1:0] req_way = '0;
   logic                   req_hit = 1'b0;
   logic [SIG_IN_BITS-1:0] req_pc_signature = '0;
   logic                   rsp_valid;
   logic [WAY_IN_BITS-1:0] rsp_evict_way;

   int fail_count;
   int pending;
   int stall_cycles;
   int ops_sent;
   bit idle_on;

   logic [SET_IN_BITS-1:0] hot_set  [HOT_SETS];
   logic [SIG_IN_BITS-1:0] sig_pick [SIG_POOL];

   always #5 clock = ~clock;

   ship_deadblock_cache_replacement u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_set_index    (req_set_index),
      .req_way          (req_way),
      .req_hit          (req_hit),
      .req_pc_signature (req_pc_signature),
      .rsp_valid        (rsp_valid),
      .rsp_evict_way    (rsp_evict_way)
   );

   ship_deadblock_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_set_index    (req_set_index),
      .req_way          (req_way),
      .req_hit          (req_hit),
      .req_pc_signature (req_pc_signature),
      .rsp_valid        (rsp_valid),
      .rsp_evict_way    (rsp_evict_way),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // watchdog on cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // issue one transaction after a random gap; entered and left at a falling edge
   task automatic send_op(input logic f, input logic [SET_IN_BITS-1:0] s,
                          input logic [WAY_IN_BITS-1:0] w, input logic h,
                          input logic [SIG_IN_BITS-1:0] g);
      int gap;
      if (ops_sent % 40 == 0) begin
         idle_on = ($urandom_range(0, 9) < 7);
      end
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_set_index    <= s;
      req_way          <= w;
      req_hit          <= h;
      req_pc_signature <= g;
      do @(posedge clock); while (busy);
      ops_sent = ops_sent + 1;
      @(negedge clock);
   endtask

   // random transaction, mostly on a few hot sets and a small signature pool
   task automatic random_op(input int query_pct, input int fill_pct);
      int                     roll;
      logic                   f;
      logic                   h;
      logic [SET_IN_BITS-1:0] s;
      logic [SIG_IN_BITS-1:0] g;
      s = ($urandom_range(0, 99) < 85) ? hot_set[$urandom_range(0, HOT_SETS - 1)]
                                        : SET_IN_BITS'($urandom_range(0, SET_TOP));
      g = ($urandom_range(0, 99) < 75) ? sig_pick[$urandom_range(0, SIG_POOL - 1)]
                                        : SIG_IN_BITS'($urandom_range(0, SIG_TOP));
      roll = $urandom_range(0, 99);
      if (roll < query_pct) begin
         f = FUNC_QUERY;
         h = 1'($urandom_range(0, 1));
      end else begin
         f = FUNC_UPDATE;
         h = (roll < query_pct + fill_pct) ? 1'b0 : 1'b1;
      end
      send_op(f, s, WAY_IN_BITS'($urandom_range(0, WAY_TOP)), h, g);
   endtask

   // hold the sender off until every owed answer has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin
      ops_sent   = 0;
      idle_on    = 1'b1;
      for (int i = 0; i < HOT_SETS; i++) begin
         hot_set[i] = SET_IN_BITS'($urandom_range(0, SET_TOP));
      end
      for (int i = 0; i < SIG_POOL; i++) begin
         sig_pick[i] = SIG_IN_BITS'($urandom_range(0, SIG_TOP));
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: untouched sets at both ends of the index range
      send_op(FUNC_QUERY, '0, '0, 1'b0, '0);
      send_op(FUNC_QUERY, SET_TOP, WAY_TOP, 1'b1, SIG_TOP);
      // fill with a weak signature inserts distant, hits saturate its counter
      send_op(FUNC_UPDATE, SET_TOP, WAY_TOP, 1'b0, SIG_TOP);
      repeat (3) send_op(FUNC_UPDATE, SET_TOP, WAY_TOP, 1'b1, SIG_TOP);
      // fill with a reused signature inserts near; old signature floors at zero
      send_op(FUNC_UPDATE, 11'd5, '0, 1'b0, SIG_TOP);
      send_op(FUNC_QUERY, 11'd5, '0, 1'b0, '0);
      // every way recent, so the query has to age the whole set
      for (int w = 0; w <= WAY_TOP; w++) begin
         send_op(FUNC_UPDATE, 11'd1, WAY_IN_BITS'(w), 1'b1, SIG_IN_BITS'(w * 4 + 3));
      end
      send_op(FUNC_QUERY, 11'd1, '0, 1'b0, '0);

      // random mix with one full pause halfway
      for (int i = 0; i < RAND_OPS; i++) begin
         if (i == RAND_OPS / 2) begin
            drain_results();
         end
         random_op(30, 35);
      end

      // query-heavy tail
      for (int i = 0; i < 40; i++) begin
         random_op(40, 30);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
